>>> rtl/dbled_pkg.sv
// Shared types and constants for the double buffered LED frame readout unit.
// No dependencies; imported by dbled_rotmod and the top-level readout unit.
package dbled_pkg;

	localparam int MAX_PIXELS   = 1024;
	localparam int IDX_W        = $clog2(MAX_PIXELS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int ADDR_W       = IDX_W + 1;
	localparam int STORE_DEPTH  = 2 * MAX_PIXELS;
	localparam int CHAN_W       = 8;
	localparam int COLOR_W      = 3 * CHAN_W;

	localparam int IN_FIELDS_W  = IDX_W + COLOR_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = COLOR_W + IDX_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = CNT_W;

	localparam int OQ_DEPTH     = 4;
	localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
	localparam int PEND_W       = OQ_PTR_W + 1;

	localparam int STEP_W       = $clog2(IDX_W);

	typedef enum logic [1:0] {
		REQ_WR_SHOWN  = 2'd0,
		REQ_WR_HIDDEN = 2'd1,
		REQ_SWAP      = 2'd2,
		REQ_FETCH     = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LED_COUNT = 2'd0,
		CFG_REVERSE   = 2'd1,
		CFG_ROTATE    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [IDX_W-1:0]   position;
		logic               last;
	} pix_out_t;

endpackage

>>> rtl/dbled_ram.sv
// Generic single port RAM with registered read data.
// No dependencies; holds the two pixel banks of the frame store.
module dbled_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/dbled_rotmod.sv
// Iterative restoring remainder unit: rotation/offset modulo LED count.
// Depends on dbled_pkg; one quotient bit per cycle.
module dbled_rotmod import dbled_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic [IDX_W-1:0] result
);

	logic             busy_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] dvd_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W-1:0] trial;
	logic             fits;
	logic [CNT_W-1:0] diff;

	assign trial = {rem_q, dvd_q[IDX_W-1]};
	assign fits  = trial >= div_q;
	assign diff  = trial - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(IDX_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[IDX_W-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign result = rem_q;

endmodule

>>> rtl/double_buffered_led_frame_readout_unit.sv
// Double buffered LED frame store: bank writes, bank swap and pixel fetch in G, R, B order.
// Depends on dbled_pkg, dbled_ram and dbled_rotmod.
//
// Takes one request per clock cycle while s_tready is high; a fetch result reaches the master
// side through the input register, the registered read of the single port pixel store and
// the output queue. After reset s_tready stays low for a clearing pass over all 2048 store
// entries, one store entry per cycle; configuration writes are taken meanwhile. After every
// configuration write s_tready stays low while the rotation and the offset latched for the
// current frame are reduced modulo the LED count, one bit per cycle. A four-entry output
// queue keeps requests flowing while a result waits on m_tready.
module double_buffered_led_frame_readout_unit import dbled_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // pixel_index, red_in, green_in, blue_in, zero pad
	input  logic [1:0]             s_tuser,  // req_type
	// pixel stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // green_out, red_out, blue_out, out_position, pad
	output logic                   m_tlast   // last_pixel
);

	logic [CNT_W-1:0] led_count_q;
	logic             reverse_q;
	logic [IDX_W-1:0] rotate_q;
	logic             rot_start_q;
	logic             rot_busy;
	logic [IDX_W-1:0] rot_mod;
	logic [CNT_W-1:0] cnt;

	logic             sp_busy;
	logic [IDX_W-1:0] sp_mod;
	logic             sp_run_q;
	logic             sp_done;

	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic               s_acc;
	logic               vld_s1;
	req_t               req_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COLOR_W-1:0] color_s1;

	logic             bank_q;
	logic [IDX_W-1:0] frame_q;
	logic [IDX_W-1:0] sp_q;
	logic [IDX_W-1:0] sp_red_q;

	logic             do_fetch;
	logic             wr_ok;
	logic [IDX_W-1:0] pos;
	logic [IDX_W-1:0] sp_sel;
	logic [IDX_W-1:0] sp_eff;
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] sum;
	logic [CNT_W-1:0] src_full;
	logic             last;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [COLOR_W-1:0] ram_wdata;
	logic [COLOR_W-1:0] ram_rdata;

	logic             res_s2;
	logic             rel_s2;
	logic [IDX_W-1:0] pos_s2;
	logic             last_s2;

	pix_out_t            oq_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [PEND_W-1:0]   oq_cnt_q;
	logic [PEND_W-1:0]   pend_q;
	logic                pop;
	pix_out_t            head;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= '0;
			reverse_q   <= 1'b0;
			rotate_q    <= '0;
			rot_start_q <= 1'b0;
			sp_run_q    <= 1'b0;
		end else begin
			rot_start_q <= cfg_valid;
			sp_run_q    <= sp_busy;
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					CFG_LED_COUNT: led_count_q <= cfg_data;
					CFG_REVERSE:   reverse_q   <= cfg_data[0];
					CFG_ROTATE:    rotate_q    <= cfg_data[IDX_W-1:0];
					default:       ;
				endcase
			end
		end
	end

	assign cnt = (led_count_q > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : led_count_q;

	dbled_rotmod u_rotmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rot_start_q),
		.dividend (rotate_q),
		.divisor  (cnt),
		.busy     (rot_busy),
		.result   (rot_mod)
	);

	dbled_rotmod u_spmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rot_start_q),
		.dividend (sp_q),
		.divisor  (cnt),
		.busy     (sp_busy),
		.result   (sp_mod)
	);

	assign sp_done = sp_run_q && !sp_busy;

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// request intake
	assign s_tready = !clr_q && !rot_busy && !rot_start_q && (pend_q < PEND_W'(OQ_DEPTH));
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_s1   <= req_t'(s_tuser);
			idx_s1   <= s_tdata[IDX_W-1:0];
			color_s1 <= s_tdata[IDX_W +: COLOR_W];
		end
	end

	// request execution
	assign pos      = ({1'b0, frame_q} >= cnt) ? '0 : frame_q;
	assign sp_sel   = (pos == '0) ? rot_mod : sp_q;
	assign sp_eff   = (pos == '0) ? rot_mod : sp_red_q;
	assign base     = reverse_q ? (cnt - CNT_W'(1) - {1'b0, pos}) : {1'b0, pos};
	assign sum      = base + {1'b0, sp_eff};
	assign src_full = (sum >= cnt) ? (sum - cnt) : sum;
	assign last     = ({1'b0, pos} == (cnt - CNT_W'(1)));
	assign do_fetch = vld_s1 && (req_s1 == REQ_FETCH) && (cnt != '0);
	assign wr_ok    = vld_s1 && ((req_s1 == REQ_WR_SHOWN) || (req_s1 == REQ_WR_HIDDEN)) &&
	                  ({1'b0, idx_s1} < cnt);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = color_s1;
		ram_addr  = {bank_q, src_full[IDX_W-1:0]};
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_wdata = '0;
			ram_addr  = clr_addr_q;
		end else if (wr_ok) begin
			ram_we   = 1'b1;
			ram_addr = {bank_q ^ (req_s1 == REQ_WR_HIDDEN), idx_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			frame_q  <= '0;
			sp_q     <= '0;
			sp_red_q <= '0;
		end else if (vld_s1 && (req_s1 == REQ_SWAP)) begin
			bank_q  <= !bank_q;
			frame_q <= '0;
		end else if (do_fetch) begin
			frame_q  <= last ? '0 : (pos + IDX_W'(1));
			sp_q     <= sp_sel;
			sp_red_q <= sp_eff;
		end else if (sp_done) begin
			sp_red_q <= sp_mod;
		end
	end

	dbled_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
			rel_s2 <= 1'b0;
		end else begin
			res_s2 <= do_fetch;
			rel_s2 <= vld_s1 && !do_fetch;
		end
	end

	always_ff @(posedge clk) begin
		pos_s2  <= pos;
		last_s2 <= last;
	end

	// output queue
	assign pop  = m_tvalid && m_tready;
	assign head = oq_mem[oq_rd_q];

	always_ff @(posedge clk) begin
		if (res_s2) begin
			oq_mem[oq_wr_q] <= '{color: ram_rdata, position: pos_s2, last: last_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
			pend_q   <= '0;
		end else begin
			if (res_s2) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + PEND_W'(res_s2) - PEND_W'(pop);
			pend_q   <= pend_q + PEND_W'(s_acc) - PEND_W'(rel_s2) - PEND_W'(pop);
		end
	end

	assign m_tvalid = (oq_cnt_q != '0);
	assign m_tlast  = head.last;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
	                   head.position,
	                   head.color[2*CHAN_W +: CHAN_W],
	                   head.color[CHAN_W-1:0],
	                   head.color[CHAN_W +: CHAN_W]};

endmodule
